// ===== rtl/ggtp_pkg.sv =====
// ggtp_pkg: shared types, constants and table functions for the gray, gamma and tint pixel core
// depends on nothing; used by gray_gamma_tint_pixel_core and ggtp_checker
package ggtp_pkg;

	typedef logic [16:0] log_val_t;
	typedef logic [31:0] exp_val_t;
	typedef logic [7:0]  pix_t;
	typedef logic [16:0] tint_t;
	typedef logic [15:0] gamma_t;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_B = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_G = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_R = 4'd3;

	localparam gamma_t GAMMA_RST  = 16'd5734;
	localparam tint_t  TINT_B_RST = 17'd0;
	localparam tint_t  TINT_G_RST = 17'd49152;
	localparam tint_t  TINT_R_RST = 17'd0;

	// luma weights, q0.16
	localparam logic [15:0] W_RED   = 16'd19661;
	localparam logic [15:0] W_GREEN = 16'd38666;
	localparam logic [15:0] W_BLUE  = 16'd7209;

	// register stages between an accepted item and its result strobe
	localparam int PIPE_DEPTH = 9;

	localparam int MAX_TAB_BITS = 12;

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		int j;
		v = v_in;
		r = 64'd0;
		b = 64'd1 << 62;
		for (j = 0; j < 32; j++) begin
			if (b > v) begin
				b = b >> 2;
			end
		end
		for (j = 0; j < 32; j++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// log2(1 + i/2^t) in q0.16, rounded
	function automatic log_val_t log_entry(input int t, input int i);
		logic [63:0] x;
		logic [31:0] y;
		int k;
		if (i >= (1 << t)) begin
			return 17'd65536;
		end
		x = 64'((1 << t) + i) << (30 - t);
		y = 32'd0;
		for (k = 0; k < 18; k++) begin
			x = (x * x) >> 30;
			y = y << 1;
			if (x >= (64'd2 << 30)) begin
				x = x >> 1;
				y = y | 32'd1;
			end
		end
		return 17'((y + 32'd2) >> 2);
	endfunction

	// 2^(i/2^t) in q2.30, rounded
	function automatic exp_val_t exp_entry(input int t, input int i);
		logic [63:0] root [MAX_TAB_BITS+1];
		logic [63:0] x;
		int k;
		if (i >= (1 << t)) begin
			return 32'd2 << 30;
		end
		root[0] = 64'd2 << 30;
		for (k = 1; k <= MAX_TAB_BITS; k++) begin
			if (k <= t) begin
				root[k] = isqrt64(root[k-1] << 30);
			end else begin
				root[k] = 64'd0;
			end
		end
		x = 64'd1 << 30;
		for (k = 0; k < MAX_TAB_BITS; k++) begin
			if ((k < t) && (((i >> k) & 1) == 1)) begin
				x = (x * root[t-k] + (64'd1 << 29)) >> 30;
			end
		end
		return 32'(x);
	endfunction

endpackage

// ===== rtl/gray_gamma_tint_pixel_core.sv =====
// gray_gamma_tint_pixel_core: pixel to luma, gamma through log2/exp2 tables, tint toward white
// depends on ggtp_pkg (types, register codes, table functions)
//
//  channel   signals                                         direction  handshake
//  pixel in  start busy in_blue in_green in_red frame_end    in         start & !busy
//  result    done out_blue out_green out_red frame_last      out        done, one cycle
//  config    cfg_valid cfg_ready cfg_index cfg_data          in         cfg_valid & cfg_ready
//
// nine register stages; one item may enter every cycle
// the stages: luma, normalise, log read, log interp, exponent multiply, exp read, exp interp, scale, tint
// busy stays low: nothing in the pipeline holds an item back
// reset clears the valid bits and loads the register defaults; no clearing pass
module gray_gamma_tint_pixel_core
	import ggtp_pkg::*;
#(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [7:0]            in_blue,
	input  logic [7:0]            in_green,
	input  logic [7:0]            in_red,
	input  logic                  frame_end,
	output logic                  done,
	output logic [7:0]            out_blue,
	output logic [7:0]            out_green,
	output logic [7:0]            out_red,
	output logic                  frame_last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TAB_N      = 1 << LOG_TABLE_BITS;
	localparam int FRAC_SHIFT = 16 - LOG_TABLE_BITS;
	localparam int LPW        = 17 + FRAC_SHIFT;
	localparam int EPW        = 32 + FRAC_SHIFT;

	// function tables
	log_val_t log_rom [TAB_N+1];
	exp_val_t exp_rom [TAB_N+1];

	for (genvar gi = 0; gi <= TAB_N; gi++) begin : g_rom
		localparam log_val_t LV = log_entry(LOG_TABLE_BITS, gi);
		localparam exp_val_t EV = exp_entry(LOG_TABLE_BITS, gi);
		assign log_rom[gi] = LV;
		assign exp_rom[gi] = EV;
	end

	// configuration
	gamma_t gamma_q;
	tint_t  tint_b_q;
	tint_t  tint_g_q;
	tint_t  tint_r_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q  <= GAMMA_RST;
			tint_b_q <= TINT_B_RST;
			tint_g_q <= TINT_G_RST;
			tint_r_q <= TINT_R_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAMMA:  gamma_q  <= cfg_data[15:0];
				REG_TINT_B: tint_b_q <= cfg_data;
				REG_TINT_G: tint_g_q <= cfg_data;
				REG_TINT_R: tint_r_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid and frame flag chains
	logic [PIPE_DEPTH-1:0] vld_q;
	logic [PIPE_DEPTH-1:0] fl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		fl_q <= {fl_q[PIPE_DEPTH-2:0], frame_end};
	end

	// stage 1: luma q8.8
	logic [23:0] wsum;
	logic [15:0] luma_s1;

	assign wsum = 24'(W_RED) * 24'(in_red) + 24'(W_GREEN) * 24'(in_green)
		+ 24'(W_BLUE) * 24'(in_blue);

	always_ff @(posedge clk) begin
		luma_s1 <= wsum[23:8];
	end

	// stage 2: leading one and normalise
	logic [3:0]  msb_pos;
	logic [15:0] norm;
	logic [15:0] frac;
	logic [3:0]  p_s2;
	logic [LOG_TABLE_BITS-1:0] lidx_s2;
	logic [FRAC_SHIFT-1:0]     lrem_s2;
	logic        zero_s2;

	always_comb begin
		msb_pos = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (luma_s1[i]) begin
				msb_pos = 4'(i);
			end
		end
	end

	assign norm = luma_s1 << (4'd15 - msb_pos);
	assign frac = {norm[14:0], 1'b0};

	always_ff @(posedge clk) begin
		p_s2    <= msb_pos;
		lidx_s2 <= frac[15:FRAC_SHIFT];
		lrem_s2 <= frac[FRAC_SHIFT-1:0];
		zero_s2 <= (luma_s1 == 16'd0);
	end

	// stage 3: log table read
	logic [LOG_TABLE_BITS:0] lidx_a;
	logic [LOG_TABLE_BITS:0] lidx_b;
	log_val_t lbase_s3;
	log_val_t ldiff_s3;
	logic [FRAC_SHIFT-1:0] lrem_s3;
	logic [3:0] p_s3;
	logic       zero_s3;

	assign lidx_a = {1'b0, lidx_s2};
	assign lidx_b = lidx_a + 1'b1;

	always_ff @(posedge clk) begin
		lbase_s3 <= log_rom[lidx_a];
		ldiff_s3 <= log_rom[lidx_b] - log_rom[lidx_a];
		lrem_s3  <= lrem_s2;
		p_s3     <= p_s2;
		zero_s3  <= zero_s2;
	end

	// stage 4: log interpolation, biased log2 in q5.16
	logic [LPW-1:0] lprod;
	logic [20:0] lgb_s4;
	logic        zero_s4;

	assign lprod = LPW'(ldiff_s3) * LPW'(lrem_s3);

	always_ff @(posedge clk) begin
		lgb_s4  <= 21'({p_s3, 16'd0}) + 21'(lbase_s3) + 21'(lprod >> FRAC_SHIFT);
		zero_s4 <= zero_s3;
	end

	// stage 5: times the exponent, rebiased so nothing goes negative
	logic [37:0] prod;
	logic [24:0] eb_s5;
	logic        zero_s5;

	assign prod = 38'(lgb_s4) * 38'(gamma_q) + (38'd1 << 36) - (38'(gamma_q) << 19);

	always_ff @(posedge clk) begin
		eb_s5   <= prod[36:12];
		zero_s5 <= zero_s4;
	end

	// stage 6: exp table read and range checks
	logic [LOG_TABLE_BITS:0] eidx_a;
	logic [LOG_TABLE_BITS:0] eidx_b;
	exp_val_t ebase_s6;
	exp_val_t ediff_s6;
	logic [FRAC_SHIFT-1:0] erem_s6;
	logic [2:0] n_s6;
	logic       fz_s6;
	logic       fs_s6;

	assign eidx_a = {1'b0, eb_s5[15:FRAC_SHIFT]};
	assign eidx_b = eidx_a + 1'b1;

	always_ff @(posedge clk) begin
		ebase_s6 <= exp_rom[eidx_a];
		ediff_s6 <= exp_rom[eidx_b] - exp_rom[eidx_a];
		erem_s6  <= eb_s5[FRAC_SHIFT-1:0];
		n_s6     <= eb_s5[18:16];
		fz_s6    <= zero_s5 | ~eb_s5[24];
		fs_s6    <= ~zero_s5 & eb_s5[24] & (|eb_s5[23:19]);
	end

	// stage 7: exp interpolation
	logic [EPW-1:0] eprod;
	exp_val_t val_s7;
	logic [2:0] n_s7;
	logic       fz_s7;
	logic       fs_s7;

	assign eprod = EPW'(ediff_s6) * EPW'(erem_s6);

	always_ff @(posedge clk) begin
		val_s7 <= ebase_s6 + 32'(eprod >> FRAC_SHIFT);
		n_s7   <= n_s6;
		fz_s7  <= fz_s6;
		fs_s7  <= fs_s6;
	end

	// stage 8: scale by the integer part, saturate
	logic [38:0] scaled;
	logic [8:0]  pw;
	pix_t        gray_s8;

	assign scaled = 39'(val_s7) << n_s7;
	assign pw     = scaled[38:30];

	always_ff @(posedge clk) begin
		priority if (fz_s7) begin
			gray_s8 <= 8'd0;
		end else if (fs_s7 || (pw > 9'd255)) begin
			gray_s8 <= 8'd255;
		end else begin
			gray_s8 <= pw[7:0];
		end
	end

	// stage 9: tint toward white
	function automatic pix_t tint_mix(input pix_t g, input tint_t t);
		logic [24:0] m;
		logic [9:0]  v;
		m = 25'(8'd255 - g) * 25'(t);
		v = 10'(g) + 10'(m[24:16]);
		return (v > 10'd255) ? 8'd255 : v[7:0];
	endfunction

	pix_t ob_s9;
	pix_t og_s9;
	pix_t or_s9;

	always_ff @(posedge clk) begin
		ob_s9 <= tint_mix(gray_s8, tint_b_q);
		og_s9 <= tint_mix(gray_s8, tint_g_q);
		or_s9 <= tint_mix(gray_s8, tint_r_q);
	end

	assign done       = vld_q[PIPE_DEPTH-1];
	assign frame_last = fl_q[PIPE_DEPTH-1];
	assign out_blue   = ob_s9;
	assign out_green  = og_s9;
	assign out_red    = or_s9;

endmodule

// ===== rtl/ggtp_checker.sv =====
// ggtp_checker: port-level timing checks for gray_gamma_tint_pixel_core, with its bind
// depends on ggtp_pkg (pipeline depth)
module ggtp_checker
	import ggtp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic frame_end,
	input logic done,
	input logic frame_last
);

	// every accepted item gives its result after the pipeline depth
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(PIPE_DEPTH) done)
		else $error("item accepted without a result");

	// no result without an item accepted
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(PIPE_DEPTH) !done)
		else $error("result with no accepted item");

	// frame flag travels with its item
	a_frame_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(PIPE_DEPTH) (frame_last == $past(frame_end, PIPE_DEPTH)))
		else $error("frame flag lost its item");

endmodule

bind gray_gamma_tint_pixel_core ggtp_checker u_ggtp_checker (.*);
